/* hw/rtl/idtu_pkg.sv */
// ----------------------------------------------------------------------------
// idtu_pkg: shared types and constants for the ISO date-time to Unix seconds
// converter (character classes, parse phases, controller/datapath bundles).
// ----------------------------------------------------------------------------
`default_nettype none

package idtu_pkg;

    localparam int YEAR_W   = 14;
    localparam int FIELD_W  = 7;
    localparam int EPOCH_W  = 39;
    localparam int TDATA_W  = 40;
    localparam int CHAR_W   = 8;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_DIG0  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIG9  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_TEE   = 8'h54;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;

    // Digits per field
    localparam logic [2:0] YEAR_DIGITS  = 3'd4;
    localparam logic [2:0] FIELD_DIGITS = 3'd2;

    // Days-from-civil constants
    localparam int DAYS_PER_ERA  = 146097;
    localparam int EPOCH_SHIFT   = 719468;
    localparam int SECS_PER_DAY  = 86400;
    localparam int MONTH_MUL     = 153;
    localparam int YEARS_PER_ERA = 400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int DAYS_PER_YEAR = 365;

    // Reciprocals: exact over the value ranges seen here
    localparam int ERA_RECIP  = 5243;   // y / 400   = (y * 5243) >> 21, y < 16384
    localparam int ERA_SHIFT  = 21;
    localparam int DIV5_RECIP = 13108;  // x / 5     = (x * 13108) >> 16, x < 16384
    localparam int DIV5_SHIFT = 16;
    localparam int C100_RECIP = 41;     // v / 100   = (v * 41) >> 12, v < 400
    localparam int C100_SHIFT = 12;

    // Conversion pipeline depth
    localparam int CONV_STEPS = 7;
    localparam int STEP_W     = $clog2(CONV_STEPS);

    typedef enum logic [2:0] {
        PH_YEAR   = 3'd0,
        PH_MONTH  = 3'd1,
        PH_DAY    = 3'd2,
        PH_HOUR   = 3'd3,
        PH_MINUTE = 3'd4,
        PH_SECOND = 3'd5,
        PH_TAIL   = 3'd6
    } t_phase;

    typedef struct packed {
        logic   acc_en;     // shift a digit into the field accumulator
        t_phase field;      // which accumulator
        logic   capture;    // latch accumulators for conversion
        logic   ok;         // parse result travelling with capture
        logic   clear;      // clear accumulators for the next string
        logic   step;       // advance the conversion pipeline
        logic   out_load;   // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic is_digit;
        logic is_zero;
        logic is_dash;
        logic is_tee;
        logic is_colon;
    } t_dp_stat;

endpackage

`default_nettype wire

/* hw/rtl/idtu_ctrl.sv */
// ----------------------------------------------------------------------------
// idtu_ctrl: controller
// Tracks the parse phase per character, sequences the conversion pipeline and
// owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module idtu_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_valid,
    output logic                    o_s_ready,
    input  wire idtu_pkg::t_dp_stat i_stat,
    output idtu_pkg::t_dp_cmd       o_cmd,
    output logic                    o_m_valid,
    input  wire logic               i_m_ready
);
    import idtu_pkg::*;

    typedef enum logic [1:0] {
        ST_PARSE,
        ST_CONV,
        ST_DONE
    } t_state;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [2:0]        r_cnt, n_cnt;
    logic              r_failed, n_failed;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;

    logic       accept;
    logic [2:0] limit;
    logic       sep_match;

    assign accept    = i_s_valid && (r_state == ST_PARSE);
    assign limit     = (r_phase == PH_YEAR) ? YEAR_DIGITS : FIELD_DIGITS;
    assign o_s_ready = (r_state == ST_PARSE);
    assign o_m_valid = r_out_valid;

    always_comb begin
        unique case (r_phase) inside
            PH_YEAR, PH_MONTH: sep_match = i_stat.is_dash;
            PH_DAY:            sep_match = i_stat.is_tee;
            PH_HOUR:           sep_match = i_stat.is_colon;
            default:           sep_match = 1'b0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_failed = r_failed;
        n_step   = r_step;
        o_cmd          = '0;
        o_cmd.field    = r_phase;

        unique case (r_state)
            ST_PARSE: begin
                if (accept) begin
                    if (r_failed || r_phase == PH_TAIL) begin
                        // skip up to the terminator
                    end else if (i_stat.is_digit && r_cnt < limit) begin
                        o_cmd.acc_en = 1'b1;
                        n_cnt        = r_cnt + 3'd1;
                    end else if (r_phase <= PH_HOUR) begin
                        if (sep_match) begin
                            n_phase = t_phase'(3'(r_phase) + 3'd1);
                            n_cnt   = '0;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end else if (r_phase == PH_MINUTE && i_stat.is_colon) begin
                        n_phase = PH_SECOND;
                        n_cnt   = '0;
                    end else begin
                        n_phase = PH_TAIL;
                    end

                    if (i_stat.is_zero) begin
                        // ok needs the minutes field reached with no failure so far
                        o_cmd.capture = 1'b1;
                        o_cmd.ok      = !r_failed && (r_phase >= PH_MINUTE);
                        o_cmd.clear   = 1'b1;
                        n_phase       = PH_YEAR;
                        n_cnt         = '0;
                        n_failed      = 1'b0;
                        n_step        = '0;
                        n_state       = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + STEP_W'(1);
                if (r_step == STEP_W'(CONV_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_PARSE;
                end
            end
            default: n_state = ST_PARSE;
        endcase

        n_out_valid = o_cmd.out_load || (r_out_valid && !i_m_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_PARSE;
            r_phase     <= PH_YEAR;
            r_cnt       <= '0;
            r_failed    <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_failed    <= n_failed;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/idtu_dp.sv */
// ----------------------------------------------------------------------------
// idtu_dp: datapath
// Character classification, field accumulators, a seven-stage days-from-civil
// pipeline and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module idtu_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [idtu_pkg::CHAR_W-1:0]     i_char,
    input  wire idtu_pkg::t_dp_cmd               i_cmd,
    output idtu_pkg::t_dp_stat                   o_stat,
    output logic [idtu_pkg::TDATA_W-1:0]         o_data,
    output logic                                 o_ok
);
    import idtu_pkg::*;

    // Character class
    logic [3:0] digit;
    assign digit           = i_char[3:0];
    assign o_stat.is_digit = (i_char >= CH_DIG0) && (i_char <= CH_DIG9);
    assign o_stat.is_zero  = (i_char == CH_NUL);
    assign o_stat.is_dash  = (i_char == CH_DASH);
    assign o_stat.is_tee   = (i_char == CH_TEE);
    assign o_stat.is_colon = (i_char == CH_COLON);

    // Field accumulators
    logic [YEAR_W-1:0]  r_year;
    logic [FIELD_W-1:0] r_month, r_day, r_hour, r_min, r_sec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_year  <= '0;
            r_month <= '0;
            r_day   <= '0;
            r_hour  <= '0;
            r_min   <= '0;
            r_sec   <= '0;
        end else if (i_cmd.acc_en) begin
            case (i_cmd.field)
                PH_YEAR:   r_year  <= r_year  * YEAR_W'(10)  + YEAR_W'(digit);
                PH_MONTH:  r_month <= r_month * FIELD_W'(10) + FIELD_W'(digit);
                PH_DAY:    r_day   <= r_day   * FIELD_W'(10) + FIELD_W'(digit);
                PH_HOUR:   r_hour  <= r_hour  * FIELD_W'(10) + FIELD_W'(digit);
                PH_MINUTE: r_min   <= r_min   * FIELD_W'(10) + FIELD_W'(digit);
                default:   r_sec   <= r_sec   * FIELD_W'(10) + FIELD_W'(digit);
            endcase
        end
    end

    // Capture: March-based year. Year 0 in Jan/Feb becomes -1, carried as a flag
    // (era 0, yoe -1, yoe/4 and yoe/100 both 0 under truncation).
    logic               early_month;
    logic               r_neg, r_ok;
    logic [YEAR_W-1:0]  r_y;
    logic [FIELD_W-1:0] r_m, r_d, r_h, r_mi, r_s;

    assign early_month = (r_month <= FIELD_W'(2));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_neg <= early_month && (r_year == '0);
            r_y   <= (early_month && (r_year != '0)) ? r_year - YEAR_W'(1) : r_year;
            r_m   <= early_month ? r_month + FIELD_W'(12) : r_month;
            r_d   <= r_day;
            r_h   <= r_hour;
            r_mi  <= r_min;
            r_s   <= r_sec;
            r_ok  <= i_cmd.ok;
        end
    end

    // Conversion pipeline; capture registers stay stable while it runs
    logic [26:0] era_prod;
    logic [14:0] yoe_full;
    logic [27:0] q5_prod;
    logic [14:0] c100_prod;
    logic signed [42:0] dsec_prod;

    logic [5:0]  r_era;
    logic [13:0] r_t153;
    logic [18:0] r_h3600;
    logic [12:0] r_mi60;
    logic [8:0]  r_yoe;
    logic [11:0] r_q5;
    logic [18:0] r_hms;
    logic [12:0] r_doyp;          // day of year plus one
    logic [17:0] r_yoe365;
    logic [6:0]  r_yoe4;
    logic [2:0]  r_yoe100;
    logic signed [19:0] r_doe;
    logic [22:0] r_era146;
    logic signed [24:0] r_days;
    logic [EPOCH_W-1:0] r_dsec;
    logic [EPOCH_W-1:0] r_sum;

    localparam logic signed [17:0] DAY_SECS = 18'(SECS_PER_DAY);

    assign era_prod  = 27'(r_y) * 27'(ERA_RECIP);
    assign yoe_full  = 15'(r_y) - 15'(r_era) * 15'(YEARS_PER_ERA);
    assign q5_prod   = 28'(r_t153) * 28'(DIV5_RECIP);
    assign c100_prod = 15'(r_yoe) * 15'(C100_RECIP);
    assign dsec_prod = r_days * DAY_SECS;

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            // stage 1
            r_era    <= era_prod[ERA_SHIFT +: 6];
            r_t153   <= (14'(r_m) - 14'd3) * 14'(MONTH_MUL) + 14'd2;
            r_h3600  <= 19'(r_h) * 19'(SECS_PER_HOUR);
            r_mi60   <= 13'(r_mi) * 13'(SECS_PER_MIN);
            // stage 2
            r_yoe    <= yoe_full[8:0];
            r_q5     <= q5_prod[DIV5_SHIFT +: 12];
            r_hms    <= r_h3600 + 19'(r_mi60) + 19'(r_s);
            // stage 3
            r_doyp   <= 13'(r_q5) + 13'(r_d);
            r_yoe365 <= 18'(r_yoe) * 18'(DAYS_PER_YEAR);
            r_yoe4   <= r_yoe[8:2];
            r_yoe100 <= c100_prod[C100_SHIFT +: 3];
            // stage 4
            r_doe    <= r_neg ? 20'(r_doyp) - 20'(DAYS_PER_YEAR + 1)
                              : 20'(r_yoe365) + 20'(r_yoe4) - 20'(r_yoe100)
                                + 20'(r_doyp) - 20'd1;
            r_era146 <= 23'(r_era) * 23'(DAYS_PER_ERA);
            // stage 5
            r_days   <= 25'(r_era146) + {{5{r_doe[19]}}, r_doe} - 25'(EPOCH_SHIFT);
            // stage 6
            r_dsec   <= dsec_prod[EPOCH_W-1:0];
            // stage 7
            r_sum    <= r_dsec + EPOCH_W'(r_hms);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_ok   <= r_ok;
            o_data <= r_ok ? TDATA_W'(r_sum) : '0;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/iso_datetime_to_unix_seconds.sv */
// ----------------------------------------------------------------------------
// iso_datetime_to_unix_seconds: streaming YYYY-MM-DDTHH:MM[:SS] parser with
// conversion to signed seconds since 1970-01-01 UTC.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                tuser
//  s_axis    in   [7:0] char_in                        -
//  m_axis    out  [38:0] epoch_seconds, [39] zero pad  [0] parse_ok
//
//  Characters are taken one per cycle. After a zero byte the input holds
//  tready low through the 7 steps of the conversion pipeline and the load
//  of the output register. The load waits while an earlier result still sits
//  unaccepted in the output register; otherwise the next string streams in
//  while the result waits. Synchronous active-low reset clears parse state,
//  accumulators and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module iso_datetime_to_unix_seconds (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] char_in
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // [38:0] epoch_seconds, [39] zero
    output logic             o_m_axis_tuser    // [0] parse_ok
);
    import idtu_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    idtu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready)
    );

    idtu_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_s_axis_tdata),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_data  (o_m_axis_tdata),
        .o_ok    (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

/* hw/rtl/idtu_checker.sv */
// ----------------------------------------------------------------------------
// idtu_checker: port-level checks for iso_datetime_to_unix_seconds
// Watches reset behavior, result hold, failed-parse payload and the input
// stall that follows a string terminator.
// ----------------------------------------------------------------------------
`default_nettype none

module idtu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [7:0]  i_s_axis_tdata,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [39:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tuser
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid not cleared by reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_fail_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == 40'd0)
        else $error("failed parse carries nonzero seconds");

    a_term_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tdata == 8'h00
            |=> !o_s_axis_tready)
        else $error("input not stalled after terminator transfer");

endmodule

bind iso_datetime_to_unix_seconds idtu_checker u_idtu_checker (.*);

`default_nettype wire
